// ===== rtl/core/dsu_pkg.sv =====
// Package for the DER ECDSA signature unpacker: constants, tag values,
// phase and error code enums, and the command record passed front to back.
// No dependencies.
package dsu_pkg;

    // Size of one raw integer in bytes (P-256).
    localparam int FIELD_BYTES = 32;
    // Width that holds a content count up to FIELD_BYTES + 1.
    localparam int CNT_W = $clog2(FIELD_BYTES + 2);

    // DER tag values.
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;

    // Length byte values with special meaning.
    localparam logic [7:0] LEN_FULL    = 8'(FIELD_BYTES + 1);
    localparam logic [7:0] LEN_NO_PAD  = 8'(FIELD_BYTES);
    localparam logic [7:0] LEN_PAD_TOP = 8'(FIELD_BYTES - 1);

    // Command queue between the parser and the result generator.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_INT_TAG,
        PH_INT_LEN,
        PH_CONTENT
    } t_phase;

    // Error codes carried on an error result.
    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NOT_SEQUENCE,
        ERR_NOT_INTEGER,
        ERR_TRUNCATED,
        ERR_TOO_LARGE
    } t_err_code;

    // One command: a run of cnt_m1 + 1 identical result bytes. The complete
    // flag applies only to the final result of the run.
    typedef struct packed {
        logic [7:0]       data;
        logic             which;
        logic             cpl;
        logic             err;
        t_err_code        code;
        logic [CNT_W-1:0] cnt_m1;
    } t_cmd;

endpackage

// ===== rtl/core/dsu_front.sv =====
// Parser front end: accepts signature bytes, tracks the DER structure and
// turns each byte into at most one command for the result generator.
// Depends on dsu_pkg.
module dsu_front
    import dsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_cur, n_cur;
    logic             r_drop, n_drop;
    logic             r_ign, n_ign;

    logic             w_accept;
    logic [CNT_W-1:0] w_left_dec;
    logic             w_fail;
    t_err_code        w_fail_code;

    assign o_ready    = !i_q_full;
    assign w_accept   = i_valid && !i_q_full;
    assign w_left_dec = (r_left != '0) ? r_left - 1'b1 : '0;

    // Command generation and error detection for the current byte.
    always_comb begin
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.which = r_cur;
        o_cmd.code  = ERR_NONE;
        w_fail      = 1'b0;
        w_fail_code = ERR_NONE;
        if (w_accept && !r_ign) begin
            case (r_phase)
                PH_SEQ_LEN: begin
                    if (i_last) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_NOT_SEQUENCE;
                    end
                end
                PH_INT_TAG: begin
                    if (i_byte != TAG_INTEGER || i_last) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_NOT_INTEGER;
                    end
                end
                PH_INT_LEN: begin
                    if (i_last) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_NOT_INTEGER;
                    end else if (i_byte > LEN_FULL) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_TOO_LARGE;
                    end else if (i_byte < LEN_NO_PAD) begin
                        // Short integer: emit the whole zero pad as one run.
                        o_push       = 1'b1;
                        o_cmd.cnt_m1 = CNT_W'(LEN_PAD_TOP - i_byte);
                        o_cmd.cpl    = (i_byte == 8'd0) && r_cur;
                    end
                end
                PH_CONTENT: begin
                    if (i_last && w_left_dec != '0) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_TRUNCATED;
                    end else if (r_drop) begin
                        if (i_byte != 8'd0) begin
                            w_fail      = 1'b1;
                            w_fail_code = ERR_TOO_LARGE;
                        end
                    end else if (i_last && !r_cur) begin
                        // Buffer ends right after r, so s is missing.
                        w_fail      = 1'b1;
                        w_fail_code = ERR_NOT_INTEGER;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.data = i_byte;
                        o_cmd.cpl  = (w_left_dec == '0) && r_cur;
                    end
                end
                default: begin
                    if (i_byte != TAG_SEQUENCE || i_last) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_NOT_SEQUENCE;
                    end
                end
            endcase
            if (w_fail) begin
                o_push      = 1'b1;
                o_cmd.data  = 8'd0;
                o_cmd.cpl   = 1'b0;
                o_cmd.err   = 1'b1;
                o_cmd.code  = w_fail_code;
                o_cmd.cnt_m1 = '0;
            end
        end
    end

    // Next parser state.
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_cur   = r_cur;
        n_drop  = r_drop;
        n_ign   = r_ign;
        if (w_accept) begin
            if (r_ign || w_fail) begin
                if (i_last) begin
                    n_phase = PH_SEQ_TAG;
                    n_left  = '0;
                    n_cur   = 1'b0;
                    n_drop  = 1'b0;
                    n_ign   = 1'b0;
                end else begin
                    n_ign = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_SEQ_LEN: n_phase = PH_INT_TAG;
                    PH_INT_TAG: n_phase = PH_INT_LEN;
                    PH_INT_LEN: begin
                        n_left = i_byte[CNT_W-1:0];
                        if (i_byte == LEN_FULL) begin
                            n_drop  = 1'b1;
                            n_phase = PH_CONTENT;
                        end else if (i_byte != 8'd0) begin
                            n_phase = PH_CONTENT;
                        end else if (!r_cur) begin
                            n_cur   = 1'b1;
                            n_phase = PH_INT_TAG;
                        end else begin
                            n_ign = 1'b1;
                        end
                    end
                    PH_CONTENT: begin
                        n_left = w_left_dec;
                        if (r_drop) begin
                            n_drop = 1'b0;
                        end else if (w_left_dec == '0) begin
                            if (!r_cur) begin
                                n_cur   = 1'b1;
                                n_phase = PH_INT_TAG;
                            end else if (i_last) begin
                                n_phase = PH_SEQ_TAG;
                                n_left  = '0;
                                n_cur   = 1'b0;
                            end else begin
                                n_ign = 1'b1;
                            end
                        end
                    end
                    default: n_phase = PH_SEQ_LEN;
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEQ_TAG;
            r_left  <= '0;
            r_cur   <= 1'b0;
            r_drop  <= 1'b0;
            r_ign   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_cur   <= n_cur;
            r_drop  <= n_drop;
            r_ign   <= n_ign;
        end
    end

endmodule

// ===== rtl/core/dsu_fifo.sv =====
// Small command queue between parser and result generator, built from
// registers with read and write pointers and an occupancy count.
// Depends on dsu_pkg.
module dsu_fifo
    import dsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dsu_back.sv =====
// Result generator: expands each queued command into one result per cycle
// while the receiver keeps up, holding each result in the output register
// until the receiver takes it. Depends on dsu_pkg.
module dsu_back
    import dsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_which,
    output logic       o_cpl,
    output logic       o_run_last,
    output logic       o_err,
    output t_err_code  o_code
);

    logic [CNT_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_data;
    logic             r_which;
    logic             r_cpl;
    logic             r_run_last;
    logic             r_err;
    t_err_code        r_code;

    logic             w_load;
    logic             w_last_item;

    // A new result enters when the register is empty or is being taken.
    assign w_load      = !i_q_empty && (!r_valid || i_ready);
    assign w_last_item = (r_idx == i_cmd.cnt_m1);
    assign o_pop       = w_load && w_last_item;

    // Run position and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_last_item ? '0 : r_idx + 1'b1;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data     <= i_cmd.data;
            r_which    <= i_cmd.which;
            r_cpl      <= i_cmd.cpl && w_last_item;
            r_run_last <= w_last_item;
            r_err      <= i_cmd.err;
            r_code     <= i_cmd.code;
        end
    end

    assign o_valid    = r_valid;
    assign o_data     = r_data;
    assign o_which    = r_which;
    assign o_cpl      = r_cpl;
    assign o_run_last = r_run_last;
    assign o_err      = r_err;
    assign o_code     = r_code;

endmodule

// ===== rtl/core/der_ecdsa_signature_unpacker_unit.sv =====
// DER ECDSA signature unpacker, top level: parser front end, command queue
// and result generator. Depends on dsu_pkg, dsu_front, dsu_fifo, dsu_back.
//
// Usage:
//   The slave stream carries one signature byte per transaction, with tlast
//   on the final byte of the buffer. The master stream carries the raw r and
//   s values, FIELD_BYTES bytes each, big-endian, r first. tlast marks the
//   last result caused by one input byte; the complete flag marks the final
//   byte of s. A failed decode gives a single error result with its code,
//   and the input is then skipped through the next byte with tlast.
// Data path and rate:
//   A byte's results pass through the command queue and the output register.
//   One input byte is taken per cycle while the four-entry queue is not full.
//   A short integer's length byte causes a zero-pad run of up to FIELD_BYTES
//   results, which the result generator produces one per cycle while the
//   receiver is ready; the parser keeps taking bytes until the queue fills.
// Reset and stalls:
//   The synchronous reset empties the queue and the output register and
//   returns the parser to waiting for a sequence tag. When the receiver
//   stalls, the output register holds its result, the queue fills, and
//   then the slave side deasserts tready.
module der_ecdsa_signature_unpacker_unit
    import dsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] complete, [11:9] error_code
    output logic [1:0]  m_tuser,   // [0] which_integer, [1] error
    output logic        m_tlast    // run_last
);

    t_cmd       w_front_cmd;
    t_cmd       w_head_cmd;
    logic       w_push;
    logic       w_pop;
    logic       w_q_full;
    logic       w_q_empty;
    logic [7:0] w_data;
    logic       w_which;
    logic       w_cpl;
    logic       w_run_last;
    logic       w_err;
    t_err_code  w_code;

    dsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .i_q_full (w_q_full),
        .o_ready  (s_tready),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    dsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_cmd   (w_head_cmd)
    );

    dsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_cmd      (w_head_cmd),
        .o_pop      (w_pop),
        .i_ready    (m_tready),
        .o_valid    (m_tvalid),
        .o_data     (w_data),
        .o_which    (w_which),
        .o_cpl      (w_cpl),
        .o_run_last (w_run_last),
        .o_err      (w_err),
        .o_code     (w_code)
    );

    // Pack the result fields onto the master stream.
    assign m_tdata = {4'd0, w_code, w_cpl, w_data};
    assign m_tuser = {w_err, w_which};
    assign m_tlast = w_run_last;

    // The final byte of s is always the end of its run and never an error.
    a_cpl_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_cpl |-> w_run_last && w_which && !w_err)
        else $error("complete result not last of run or not from s");

    // An error result stands alone and carries a zero byte.
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_err |-> w_run_last && w_data == 8'd0 && !w_cpl)
        else $error("error result malformed");

    // The error flag and a nonzero error code always go together.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (w_err == (w_code != ERR_NONE)))
        else $error("error flag and code disagree");

    // The parser never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("command pushed into full queue");

endmodule

// ===== tb/sv/tb_der_ecdsa_signature_unpacker_unit.sv =====
// Self-checking testbench for der_ecdsa_signature_unpacker_unit: a directed
// table of DER bytes followed by random well-formed and broken signatures,
// with every result checked against a behavioral decoder. Depends on dsu_pkg.
module tb_der_ecdsa_signature_unpacker_unit;
    import dsu_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 50;
    localparam int DRAIN_CYCLES = 16;

    // One raw result as it leaves the master stream.
    typedef struct packed {
        logic [7:0] value;
        logic       which;
        logic       cpl;
        logic       run_last;
        logic       err;
        t_err_code  code;
    } t_raw_result;

    // How a directed row is checked: by the decoder, as giving no result, or against a typed error result.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_QUIET,
        CHK_ERROR
    } t_row_check;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
        t_row_check chk;
        t_err_code  code;
        logic       which;
    } t_der_row;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tlast  = 1'b0;    // in_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [8] complete, [11:9] error_code
    logic [1:0]  m_tuser;            // [0] which_integer, [1] error
    logic        m_tlast;            // run_last

    int cycle_count     = 0;
    int fail_count      = 0;
    int bytes_taken     = 0;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;

    // Decoder state mirrored from the block.
    t_phase      prs_phase;
    logic [5:0]  bytes_left;
    logic        on_s;
    logic        strip_zero;
    logic        skip_to_last;

    // Results caused by the latest byte, and results still owed by the block.
    t_raw_result step_out [FIELD_BYTES];
    int          step_n;
    t_raw_result raw_bytes_due [$];

    // Directed stimulus: framing errors, extreme lengths and a short signature.
    t_der_row directed_rows [28] = '{
        '{8'h31,        1'b0, CHK_ERROR, ERR_NOT_SEQUENCE, 1'b0},
        '{8'h00,        1'b1, CHK_QUIET, ERR_NONE,         1'b0},
        '{TAG_SEQUENCE, 1'b1, CHK_ERROR, ERR_NOT_SEQUENCE, 1'b0},
        '{TAG_SEQUENCE, 1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h7F,        1'b1, CHK_ERROR, ERR_NOT_SEQUENCE, 1'b0},
        '{TAG_SEQUENCE, 1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'hFF,        1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{TAG_INTEGER,  1'b1, CHK_ERROR, ERR_NOT_INTEGER,  1'b0},
        '{TAG_SEQUENCE, 1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h00,        1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{TAG_INTEGER,  1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h22,        1'b0, CHK_ERROR, ERR_TOO_LARGE,    1'b0},
        '{8'h55,        1'b1, CHK_QUIET, ERR_NONE,         1'b0},
        '{TAG_SEQUENCE, 1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h45,        1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{TAG_INTEGER,  1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{LEN_FULL,     1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h80,        1'b0, CHK_ERROR, ERR_TOO_LARGE,    1'b0},
        '{8'h00,        1'b1, CHK_QUIET, ERR_NONE,         1'b0},
        '{TAG_SEQUENCE, 1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h06,        1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{TAG_INTEGER,  1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h01,        1'b0, CHK_MODEL, ERR_NONE,         1'b0},
        '{8'hFF,        1'b0, CHK_MODEL, ERR_NONE,         1'b0},
        '{TAG_INTEGER,  1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'h00,        1'b0, CHK_MODEL, ERR_NONE,         1'b0},
        '{8'hAB,        1'b0, CHK_QUIET, ERR_NONE,         1'b0},
        '{8'hCD,        1'b1, CHK_QUIET, ERR_NONE,         1'b0}
    };

    der_ecdsa_signature_unpacker_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Abort a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("der_ecdsa_signature_unpacker_unit verification failed");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic string describe(input t_raw_result r);
        return $sformatf("byte %h which %0d cpl %0d last %0d err %0d code %0d",
                         r.value, r.which, r.cpl, r.run_last, r.err, r.code);
    endfunction

    function automatic void clear_decoder();
        prs_phase    = PH_SEQ_TAG;
        bytes_left   = '0;
        on_s         = 1'b0;
        strip_zero   = 1'b0;
        skip_to_last = 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] v, input logic e, input t_err_code c);
        step_out[step_n] = '{value: v, which: on_s, cpl: 1'b0, run_last: 1'b0,
                             err: e, code: c};
        step_n++;
    endfunction

    // An error result ends the signature now, or after the next last byte.
    function automatic void reject(input t_err_code c, input logic l);
        emit(8'h00, 1'b1, c);
        if (l) begin
            clear_decoder();
        end else begin
            skip_to_last = 1'b1;
        end
    endfunction

    // After the final byte of r, move on to s; after the final byte of s, stop.
    function automatic void close_integer(input logic l);
        if (!on_s) begin
            on_s      = 1'b1;
            prs_phase = PH_INT_TAG;
        end else begin
            step_out[step_n-1].cpl = 1'b1;
            if (l) begin
                clear_decoder();
            end else begin
                skip_to_last = 1'b1;
            end
        end
    endfunction

    // Work out the raw results that one DER byte causes.
    function automatic void decode_der_byte(input logic [7:0] b, input logic l);
        step_n = 0;
        if (skip_to_last) begin
            if (l) begin
                clear_decoder();
            end
        end else begin
            case (prs_phase)
                PH_SEQ_LEN: begin
                    if (l) begin
                        reject(ERR_NOT_SEQUENCE, l);
                    end else begin
                        prs_phase = PH_INT_TAG;
                    end
                end
                PH_INT_TAG: begin
                    if (b != TAG_INTEGER || l) begin
                        reject(ERR_NOT_INTEGER, l);
                    end else begin
                        prs_phase = PH_INT_LEN;
                    end
                end
                PH_INT_LEN: begin
                    if (l) begin
                        reject(ERR_NOT_INTEGER, l);
                    end else if (b > LEN_FULL) begin
                        reject(ERR_TOO_LARGE, l);
                    end else begin
                        bytes_left = b[5:0];
                        if (b == LEN_FULL) begin
                            strip_zero = 1'b1;
                            prs_phase  = PH_CONTENT;
                        end else begin
                            // The whole zero pad leaves with the length byte.
                            repeat (FIELD_BYTES - int'(b)) emit(8'h00, 1'b0, ERR_NONE);
                            if (b == 8'h00) begin
                                close_integer(1'b0);
                            end else begin
                                prs_phase = PH_CONTENT;
                            end
                        end
                    end
                end
                PH_CONTENT: begin
                    if (bytes_left != 0) begin
                        bytes_left--;
                    end
                    if (strip_zero) begin
                        if (l && bytes_left != 0) begin
                            reject(ERR_TRUNCATED, l);
                        end else if (b != 8'h00) begin
                            reject(ERR_TOO_LARGE, l);
                        end else begin
                            strip_zero = 1'b0;
                        end
                    end else if (l && bytes_left != 0) begin
                        reject(ERR_TRUNCATED, l);
                    end else if (l && !on_s) begin
                        // The buffer ends right after r, so s is missing.
                        reject(ERR_NOT_INTEGER, l);
                    end else begin
                        emit(b, 1'b0, ERR_NONE);
                        if (bytes_left == 0) begin
                            close_integer(l);
                        end
                    end
                end
                default: begin
                    if (b != TAG_SEQUENCE || l) begin
                        reject(ERR_NOT_SEQUENCE, l);
                    end else begin
                        prs_phase = PH_SEQ_LEN;
                    end
                end
            endcase
        end
        if (step_n > 0) begin
            step_out[step_n-1].run_last = 1'b1;
        end
    endfunction

    function automatic void queue_decoded();
        for (int k = 0; k < step_n; k++) begin
            raw_bytes_due.push_back(step_out[k]);
        end
    endfunction

    // Offer one byte on the slave stream and wait for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        bytes_taken++;
    endtask

    // One signature: mostly well formed with random content and lengths,
    // the rest corrupted, cut short, or plain noise. The final byte is last.
    task automatic send_random_signature();
        logic [7:0] sig [$];
        int         len;
        int         pick;
        int         pos;
        sig.push_back(TAG_SEQUENCE);
        sig.push_back(8'($urandom));
        for (int k = 0; k < 2; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = $urandom_range(0, 2);
            end else if (pick < 80) begin
                len = $urandom_range(FIELD_BYTES - 2, FIELD_BYTES + 1);
            end else begin
                len = $urandom_range(0, FIELD_BYTES + 1);
            end
            sig.push_back(TAG_INTEGER);
            sig.push_back(8'(len));
            for (int j = 0; j < len; j++) begin
                if (j == 0 && len == FIELD_BYTES + 1 && $urandom_range(0, 4) != 0) begin
                    sig.push_back(8'h00);
                end else begin
                    sig.push_back(8'($urandom));
                end
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) sig.push_back(8'($urandom));
        end

        // Break a share of the signatures.
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            pos = ($urandom_range(0, 1) == 1) ? 3 : $urandom_range(0, sig.size() - 1);
            sig[pos] = 8'($urandom);
        end else if (pick < 24) begin
            pos = $urandom_range(1, sig.size());
            sig = sig[0:pos-1];
        end else if (pick < 30) begin
            sig.delete();
            repeat ($urandom_range(1, 4)) sig.push_back(8'($urandom));
        end

        foreach (sig[j]) begin
            send_byte(sig[j], j == sig.size() - 1);
            decode_der_byte(sig[j], j == sig.size() - 1);
            queue_decoded();
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (raw_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int stop_at;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        stop_at         = bytes_taken + PHASE_BYTES;
        while (bytes_taken < stop_at) begin
            send_random_signature();
        end
        wait_for_drain();
    endtask

    // Check each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_raw_result got;
        t_raw_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{value: m_tdata[7:0], which: m_tuser[0], cpl: m_tdata[8],
                    run_last: m_tlast, err: m_tuser[1], code: t_err_code'(m_tdata[11:9])};
            if (raw_bytes_due.size() == 0) begin
                $display("%0t: unexpected result: %s", $time, describe(got));
                fail_count++;
            end else begin
                want = raw_bytes_due.pop_front();
                if (got.value != want.value || got.which != want.which ||
                    got.cpl != want.cpl || got.run_last != want.run_last ||
                    got.err != want.err || got.code != want.code) begin
                    $display("%0t: mismatch: expected %s, actual %s",
                             $time, describe(want), describe(got));
                    fail_count++;
                end
            end
        end
    end

    // Reset, directed table, random phases, then the verdict.
    initial begin
        t_raw_result typed;
        clear_decoder();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].data, directed_rows[r].is_last);
            decode_der_byte(directed_rows[r].data, directed_rows[r].is_last);
            typed = '{value: 8'h00, which: directed_rows[r].which, cpl: 1'b0,
                      run_last: 1'b1, err: 1'b1, code: directed_rows[r].code};
            case (directed_rows[r].chk)
                CHK_QUIET: begin
                    if (step_n != 0) begin
                        $display("%0t: row %0d: expected no result, decoder gives %0d",
                                 $time, r, step_n);
                        fail_count++;
                    end
                end
                CHK_ERROR: begin
                    if (step_n != 1 || step_out[0] != typed) begin
                        $display("%0t: row %0d: expected %s, decoder gives %0d results",
                                 $time, r, describe(typed), step_n);
                        fail_count++;
                    end
                    raw_bytes_due.push_back(typed);
                end
                default: begin
                    queue_decoded();
                end
            endcase
        end
        // Hold the sender off until the block has delivered everything.
        wait_for_drain();

        run_random_phase(0, 0);
        run_random_phase(65, 0);
        run_random_phase(0, 65);
        run_random_phase(17, 17);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && raw_bytes_due.size() == 0) begin
            $display("der_ecdsa_signature_unpacker_unit verification clean");
        end else begin
            $display("der_ecdsa_signature_unpacker_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dsu_pkg.sv
rtl/core/dsu_front.sv
rtl/core/dsu_fifo.sv
rtl/core/dsu_back.sv
rtl/core/der_ecdsa_signature_unpacker_unit.sv
tb/sv/tb_der_ecdsa_signature_unpacker_unit.sv
